### hw/rtl/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

  // Field widths
  localparam int VALUE_W  = 31;
  localparam int BCNT_W   = 9;
  localparam int BIDX_W   = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int NUM_BUCKETS_DEF = 256;
  localparam int BUCKET_WAYS_DEF = 8;

  localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(256);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/chs_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module chs_mod (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [chs_pkg::VALUE_W-1:0]   dividend,
  input  wire [chs_pkg::BCNT_W-1:0]    divisor,
  output logic                         done,
  output logic [chs_pkg::BCNT_W-1:0]   rem
);
  import chs_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic                  running;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_W-1:0]    dvd;
  logic [BCNT_W-1:0]     dsr;
  logic [BCNT_W:0]       trial;
  logic [BCNT_W:0]       diff;

  assign trial = {rem, dvd[VALUE_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(VALUE_W);
        dvd     <= dividend;
        dsr     <= divisor;
        rem     <= '0;
      end else if (running) begin
        // trial < 2*dsr, so the difference fits in BCNT_W bits
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[BCNT_W-1:0];
        end else begin
          rem <= trial[BCNT_W-1:0];
        end
        dvd <= {dvd[VALUE_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/chained_hash_set.sv
`timescale 1ns / 1ps
`default_nettype none

// Bucketed hash set of 31-bit values. Each command (search, insert, delete)
// is taken when start is high and busy is low, and returns one result beat
// on found/status/bucket_index, flagged by done for a single cycle; the
// receiver cannot stall, so results must be sampled when done is high. Busy
// stays high for the whole command, so a new command is taken at the
// earliest while done for the previous result is high. Each command first
// runs the bit-serial remainder unit: a load, then 31 steps for value mod
// bucket count. After that the bucket number is latched, the bucket is read,
// and a compare/write-back step follows. After reset the block sweeps the
// bucket memory to clear all valid marks, with busy high. The user should
// write the bucket_count register through cfg_valid/cfg_ready only while no
// command is in flight; the block itself does not enforce this. Zero acts as
// one and values above NUM_BUCKETS saturate.
module chained_hash_set #(
  parameter int NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_WAYS = chs_pkg::BUCKET_WAYS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  // command channel
  input  wire                            start,
  output logic                           busy,
  input  wire [chs_pkg::KIND_W-1:0]      kind,
  input  wire [chs_pkg::VALUE_W-1:0]     value,
  // result channel
  output logic                           done,
  output logic                           found,
  output logic [chs_pkg::STATUS_W-1:0]   status,
  output logic [chs_pkg::BIDX_W-1:0]     bucket_index,
  // config write channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [chs_pkg::BCNT_W-1:0]      cfg_data
);
  import chs_pkg::*;

  localparam int ADDR_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int VAL_BITS = BUCKET_WAYS * VALUE_W;
  // row layout: {valid[WAYS-1:0], value[WAYS-1] ... value[0]}
  localparam int ROW_W  = BUCKET_WAYS * (VALUE_W + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_LOOK
  } state_t;

  state_t               state;
  logic [BCNT_W-1:0]    bucket_count;
  logic [BCNT_W-1:0]    eff_div;
  logic [ADDR_W-1:0]    clr_addr;
  logic [ADDR_W-1:0]    row_addr;
  logic [KIND_W-1:0]    op_kind;
  logic [VALUE_W-1:0]   op_value;

  logic                 mod_done;
  logic [BCNT_W-1:0]    mod_rem;
  logic                 accept;

  // bucket memory
  logic [ROW_W-1:0]     mem [NUM_BUCKETS];
  logic [ROW_W-1:0]     rd_row;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ROW_W-1:0]     mem_wdata;

  // lookup
  logic [BUCKET_WAYS-1:0] row_valid;
  logic [BUCKET_WAYS-1:0] hit;
  logic                   any_hit;
  logic                   any_free;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       free_way;
  logic                   ins_ok;
  logic                   del_ok;
  logic [ROW_W-1:0]       new_row;
  logic                   found_next;
  logic [STATUS_W-1:0]    status_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective divisor: zero acts as one, saturate at the bucket count.
  always_comb begin
    if (bucket_count == '0) begin
      eff_div = BCNT_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      eff_div = BCNT_W'(NUM_BUCKETS);
    end else begin
      eff_div = bucket_count;
    end
  end

  chs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (value),
    .divisor  (eff_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Compare all ways of the bucket; lowest way wins for both hit and free.
  always_comb begin
    row_valid = rd_row[VAL_BITS +: BUCKET_WAYS];
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      hit[w] = row_valid[w] && (rd_row[w*VALUE_W +: VALUE_W] == op_value);
    end
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
    any_hit  = |hit;
    any_free = ~&row_valid;
    ins_ok   = (op_kind == KIND_INSERT) && any_free;
    del_ok   = (op_kind == KIND_DELETE) && any_hit;

    new_row = rd_row;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (ins_ok && (WAY_W'(w) == free_way)) begin
        new_row[w*VALUE_W +: VALUE_W] = op_value;
        new_row[VAL_BITS + w]         = 1'b1;
      end
      if (del_ok && (WAY_W'(w) == hit_way)) begin
        new_row[VAL_BITS + w] = 1'b0;
      end
    end

    found_next  = 1'b0;
    status_next = ST_DONE;
    case (op_kind)
      KIND_SEARCH: begin
        found_next = any_hit;
      end
      KIND_INSERT: begin
        status_next = any_free ? ST_DONE : ST_FULL;
      end
      KIND_DELETE: begin
        found_next  = any_hit;
        status_next = any_hit ? ST_DONE : ST_NOT_FOUND;
      end
      default: begin
        // unused code: plain result, no update
      end
    endcase
  end

  // Write port: clearing sweep after reset, else write-back of the bucket.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = new_row;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_LOOK) begin
      mem_we = ins_ok || del_ok;
    end
  end

  // Commands are serialized, so a read never overlaps a pending write-back.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= mem[row_addr];
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  // Control and registered result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_kind  <= kind;
            op_value <= value;
            state    <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            row_addr     <= ADDR_W'(mod_rem);
            bucket_index <= mod_rem[BIDX_W-1:0];
            state        <= S_READ;
          end
        end
        S_READ: begin
          // bucket row lands in rd_row at this edge
          state <= S_LOOK;
        end
        S_LOOK: begin
          found  <= found_next;
          status <= status_next;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/chained_hash_set_test.sv
`timescale 1ns / 1ps

// Bench for the bucketed hash set. Commands go out through start/busy, results
// come back one beat per command on done, and the bucket count register goes
// through its own valid/ready channel. A mirror of the table (value and valid
// per way) predicts every result at the edge that takes the command.
module chained_hash_set_test;

  import chs_pkg::*;

  localparam int NB    = NUM_BUCKETS_DEF;
  localparam int WAYS  = BUCKET_WAYS_DEF;
  localparam int SLOTS = NB * WAYS;

  // kind three is not a real operation; the block answers it and changes nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // random stretch of the run
  localparam int PHASE_ITEMS = 70;
  // with this few entries left in the backlog the driver stops idling
  localparam int CALM_TAIL   = 100;
  // settle at the end for longer than one command takes in the block
  localparam int SETTLE      = 40;

  typedef enum logic [1:0] {BEAT_CMD, BEAT_CFG, BEAT_DRAIN} beat_t;

  typedef struct {
    beat_t              tag;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [BCNT_W-1:0]  bcnt;
  } work_t;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bidx;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [KIND_W-1:0] kind = '0;
  logic [VALUE_W-1:0] value = '0;
  logic cfg_valid = 1'b0;
  logic [BCNT_W-1:0] cfg_data = '0;
  logic busy, done, found, cfg_ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0] bucket_index;

  chained_hash_set DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .done(done),
    .found(found),
    .status(status),
    .bucket_index(bucket_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a run that hangs.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Mirror of the table. Reset happens once, so the declarations hold it.
  // ---------------------------------------------------------------------
  logic [VALUE_W-1:0] slot_val [SLOTS];
  bit   [SLOTS-1:0]   slot_vld = '0;
  logic [BCNT_W-1:0]  bucket_cnt = BCNT_RESET;

  outcome_t results_due[$];
  work_t    cmd_backlog[$];
  logic [VALUE_W-1:0] recent_vals[$];

  int errors = 0;
  int gap_left = 0;
  int rst_cycles = 0;
  int n_kind[4] = '{0, 0, 0, 0};
  int n_hits = 0, n_full = 0, n_miss = 0, n_cfg = 0;

  // Applies one command to the mirror and returns the result it must produce.
  // Zero buckets acts as one, anything above the table size saturates.
  function automatic outcome_t hash_set_apply(logic [KIND_W-1:0] op,
                                              logic [VALUE_W-1:0] v);
    int unsigned eff, bkt, base;
    outcome_t r;
    bit hit;
    eff = (bucket_cnt == 0) ? 1 : ((bucket_cnt > NB) ? NB : bucket_cnt);
    bkt = v % eff;
    base = bkt * WAYS;
    r = '0;
    r.bidx = bkt[BIDX_W-1:0];
    hit = 1'b0;
    case (op)
      KIND_SEARCH: begin
        for (int w = 0; w < WAYS; w++)
          if (!hit && slot_vld[base+w] && slot_val[base+w] == v) hit = 1'b1;
        r.found = hit;
      end
      KIND_INSERT: begin
        // lowest free way wins; duplicates are fine
        r.status = ST_FULL;
        for (int w = 0; w < WAYS; w++)
          if (!hit && !slot_vld[base+w]) begin
            hit = 1'b1;
            slot_vld[base+w] = 1'b1;
            slot_val[base+w] = v;
            r.status = ST_DONE;
          end
      end
      KIND_DELETE: begin
        // lowest matching way is dropped; a miss leaves the table alone
        r.status = ST_NOT_FOUND;
        for (int w = 0; w < WAYS; w++)
          if (!hit && slot_vld[base+w] && slot_val[base+w] == v) begin
            hit = 1'b1;
            slot_vld[base+w] = 1'b0;
            r.found = 1'b1;
            r.status = ST_DONE;
          end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: resets, then walks the backlog. Config beats and drain markers
  // hold until every outstanding result is back, so the block is idle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic start_n, cfgv_n;
    work_t w;
    start_n = start;
    cfgv_n = cfg_valid;
    if (rst_cycles < 5) begin
      rst_cycles <= rst_cycles + 1;
      if (rst_cycles == 4) rst <= 1'b0;
    end else begin
      if (start && !busy) begin
        start_n = 1'b0;
        // The gap lands at a random offset into the running command, so the
        // next start shows up early, right on done, or well after it.
        if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(0, 36) + $urandom_range(1, 17);
      end
      if (cfg_valid && cfg_ready) cfgv_n = 1'b0;
      if (!start_n && !cfgv_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          case (cmd_backlog[0].tag)
            BEAT_CMD: begin
              w = cmd_backlog.pop_front();
              start_n = 1'b1;
              kind <= w.kind;
              value <= w.value;
            end
            BEAT_CFG: begin
              if (!start && results_due.size() == 0) begin
                w = cmd_backlog.pop_front();
                cfgv_n = 1'b1;
                cfg_data <= w.bcnt;
              end
            end
            default: begin
              if (!start && results_due.size() == 0) w = cmd_backlog.pop_front();
            end
          endcase
        end
      end
      start <= start_n;
      cfg_valid <= cfgv_n;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks a result beat against the oldest prediction first, then
  // predicts a command taken on this edge, then picks up a register write.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (done) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing pending (found %0b status %0d bucket %0d)",
                   $time, found, status, bucket_index);
        end else begin
          want = results_due.pop_front();
          if (found !== want.found) begin
            errors++;
            $display("%0t ns: found expected %0b got %0b", $time, want.found, found);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t ns: status expected %0d got %0d", $time, want.status, status);
          end
          if (bucket_index !== want.bidx) begin
            errors++;
            $display("%0t ns: bucket_index expected %0d got %0d",
                     $time, want.bidx, bucket_index);
          end
        end
      end
      if (start && !busy) begin
        want = hash_set_apply(kind, value);
        results_due.push_back(want);
        n_kind[kind]++;
        if (want.found) n_hits++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NOT_FOUND) n_miss++;
      end
      if (cfg_valid && cfg_ready) begin
        bucket_cnt = cfg_data;
        n_cfg++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic void queue_cmd(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v);
    work_t w;
    w = '{tag: BEAT_CMD, kind: k, value: v, bcnt: '0};
    cmd_backlog.push_back(w);
    if (k == KIND_INSERT) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endfunction

  function automatic void queue_marker(beat_t t, logic [BCNT_W-1:0] b);
    work_t w;
    w = '{tag: t, kind: '0, value: '0, bcnt: b};
    cmd_backlog.push_back(w);
  endfunction

  // Values lean toward a few buckets and toward values already inserted, so
  // buckets fill up and searches/deletes actually hit.
  function automatic logic [VALUE_W-1:0] pick_value(int unsigned eff);
    int unsigned spread;
    logic [31:0] v;
    spread = (eff > 4) ? 3 : eff - 1;
    case ($urandom_range(0, 5))
      0, 1: begin
        if (recent_vals.size() > 0)
          return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        v = $urandom_range(0, 63);
      end
      2: v = eff * $urandom_range(0, 1000) + $urandom_range(0, spread);
      3: v = 32'h7fff_ffff - eff * $urandom_range(0, 50) - $urandom_range(0, spread);
      4: v = $urandom;
      default: v = $urandom_range(0, 63);
    endcase
    return v[VALUE_W-1:0];
  endfunction

  initial begin
    logic [BCNT_W-1:0] settings [10];
    int unsigned eff, r;
    logic [KIND_W-1:0] k;

    // Directed, at the reset bucket count of 256.
    queue_cmd(KIND_INSERT, 31'd0);
    queue_cmd(KIND_INSERT, 31'h7fff_ffff);
    queue_cmd(KIND_SEARCH, 31'd0);
    queue_cmd(KIND_SEARCH, 31'h7fff_ffff);
    queue_cmd(KIND_SEARCH, 31'd5);
    queue_cmd(KIND_DELETE, 31'd5);          // miss: nothing changes
    queue_cmd(KIND_DELETE, 31'd0);
    queue_cmd(KIND_SEARCH, 31'd0);          // gone now
    queue_cmd(KIND_UNUSED, 31'h7fff_ffff);  // ignored, bucket still reported
    // bucket 3: a duplicate plus six more fills all eight ways
    queue_cmd(KIND_INSERT, 31'd3);
    queue_cmd(KIND_INSERT, 31'd3);
    for (int i = 1; i < WAYS - 1; i++) queue_cmd(KIND_INSERT, 31'(3 + NB * i));
    queue_cmd(KIND_INSERT, 31'(3 + NB * 7)); // bucket full
    queue_cmd(KIND_DELETE, 31'd3);           // drops the lower copy only
    queue_cmd(KIND_SEARCH, 31'd3);           // other copy still there
    queue_cmd(KIND_INSERT, 31'(3 + NB * 7)); // refills the freed way

    // Random phases; the zero and above-range settings hit the clamps, and
    // entries from older settings stay where they were placed.
    settings = '{9'd1, 9'd0, 9'd511, 9'd257, 9'd7, 9'd13, 9'd2, 9'd100, 9'd255, 9'd256};
    foreach (settings[p]) begin
      queue_marker(BEAT_CFG, settings[p]);
      eff = (settings[p] == 0) ? 1 : ((settings[p] > NB) ? NB : settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        k = (r < 40) ? KIND_INSERT : (r < 65) ? KIND_SEARCH :
            (r < 95) ? KIND_DELETE : KIND_UNUSED;
        queue_cmd(k, pick_value(eff));
        // now and then let the block run dry mid-phase
        if ($urandom_range(0, 39) == 0) queue_marker(BEAT_DRAIN, '0);
      end
    end
    queue_marker(BEAT_DRAIN, '0);

    do @(posedge clk);
    while (cmd_backlog.size() > 0 || start || cfg_valid || results_due.size() > 0);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d searches, %0d inserts, %0d deletes, %0d unused-kind commands",
             n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    $display("over %0d bucket-count writes: %0d hits, %0d full buckets, %0d delete misses",
             n_cfg, n_hits, n_full, n_miss);
    if (errors == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
